// ----- sv/owrs_pkg.sv -----
// ----------------------------------------------------------------------------
// owrs_pkg
// Types, codes and helper functions shared by the ROM search engine.
// ----------------------------------------------------------------------------
package owrs_pkg;

    typedef enum logic [1:0] {
        FUNC_FIRST  = 2'd0,
        FUNC_NEXT   = 2'd1,
        FUNC_TARGET = 2'd2,
        FUNC_RESP   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STAT_FOUND   = 2'd0,
        STAT_NO_MORE = 2'd1,
        STAT_ERROR   = 2'd2
    } status_t;

    typedef enum logic {
        KIND_REQ     = 1'b0,
        KIND_OUTCOME = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  request_byte;
        logic        last;
        status_t     status;
        logic [63:0] rom_id;
        logic [3:0]  family_discrepancy;
        logic        last_device;
    } res_t;

    // discrepancy value loaded by a target setup
    localparam logic [6:0] LD_TARGET = 7'd64;
    // discrepancy value that marks a broken search
    localparam logic [6:0] LD_BROKEN = 7'd63;
    // response count of the final response byte (echo is count zero)
    localparam logic [4:0] RESP_FINAL = 5'd16;
    // index of the final request byte
    localparam logic [3:0] REQ_FINAL = 4'd15;
    // reflected polynomial of the dallas crc-8
    localparam logic [7:0] CRC_POLY = 8'h8C;

    // one byte through the crc-8, lsb first
    function automatic logic [7:0] crc_step(logic [7:0] crc_in, logic [7:0] b);
        logic [7:0] crc;
        logic       mix;
        crc = crc_in;
        for (int n = 0; n < 8; n++)
        begin
            mix = crc[0] ^ b[n];
            crc = crc >> 1;
            if (mix)
            begin
                crc = crc ^ CRC_POLY;
            end
        end
        return crc;
    endfunction

endpackage

// ----- sv/owrs_in_if.sv -----
// ----------------------------------------------------------------------------
// owrs_in_if
// Command and response byte channel into the ROM search engine.
// ----------------------------------------------------------------------------
interface owrs_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] data;

    modport source (output valid, output func, output data, input ready);
    modport sink   (input valid, input func, input data, output ready);
endinterface

// ----- sv/owrs_out_if.sv -----
// ----------------------------------------------------------------------------
// owrs_out_if
// Request byte and search outcome channel out of the ROM search engine.
// ----------------------------------------------------------------------------
interface owrs_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  request_byte;
    logic        last;
    logic [1:0]  status;
    logic [63:0] rom_id;
    logic [3:0]  family_discrepancy;
    logic        last_device;

    modport source (output valid, output kind, output request_byte, output last,
                    output status, output rom_id, output family_discrepancy,
                    output last_device, input ready);
    modport sink   (input valid, input kind, input request_byte, input last,
                    input status, input rom_id, input family_discrepancy,
                    input last_device, output ready);
endinterface

// ----- sv/onewire_rom_search_engine.sv -----
// ----------------------------------------------------------------------------
// onewire_rom_search_engine
// 1-Wire ROM search engine for a search-accelerator bridge.
// ----------------------------------------------------------------------------
// usage
//   cmd carries commands (first search, next search, target family setup) and
//   the response bytes from the bridge; res carries request bytes to send to
//   the bridge and one search outcome at the end of each pass
//   an item on cmd lands in an input register and is processed once no request
//   burst runs and the output slot is free, which loads any outcome into the
//   output register that drives res; the first request byte of a search passes
//   the request generator's busy register and then the output register
//   response bytes and target setups go at one item per cycle while res does not stall
//   a search command makes the request generator emit sixteen request bytes,
//   one per cycle unless res stalls; cmd items wait until the burst ends
//   a next search after the last device gives a single outcome instead
//   when res stalls, the output register holds its item and the input
//   register fills, after which cmd ready drops until res drains
//   reset clears the search state, so the first pass starts from scratch
// ----------------------------------------------------------------------------
module onewire_rom_search_engine (
    input  logic clk,
    input  logic rst_n,
    owrs_in_if.sink    cmd,
    owrs_out_if.source res
);
    import owrs_pkg::*;

    // input register
    logic       s1_valid_reg, s1_valid_next;
    logic [1:0] s1_func_reg;
    logic [7:0] s1_data_reg;

    // output register
    logic       out_valid_reg, out_valid_next;
    res_t       out_res_reg;

    logic        out_free;
    logic        advance;
    logic        core_valid;
    res_t        core_res;
    logic        start_req;
    logic [63:0] stored_rom;
    logic [6:0]  last_disc;
    logic        gen_busy;
    logic        gen_emit;
    res_t        gen_res;
    logic        load;

    // output slot is free when empty or being taken this cycle
    assign out_free  = !out_valid_reg || res.ready;
    // input register moves on once no burst runs and the output slot is free
    assign advance   = s1_valid_reg && !gen_busy && out_free;
    assign cmd.ready = !s1_valid_reg || advance;
    assign load      = core_valid || gen_emit;

    owrs_search_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (advance),
        .func       (s1_func_reg),
        .data       (s1_data_reg),
        .res_valid  (core_valid),
        .res        (core_res),
        .start_req  (start_req),
        .stored_rom (stored_rom),
        .last_disc  (last_disc)
    );

    owrs_req_gen u_req (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start_req),
        .out_free   (out_free),
        .stored_rom (stored_rom),
        .last_disc  (last_disc),
        .busy       (gen_busy),
        .emit       (gen_emit),
        .res        (gen_res)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (cmd.valid && cmd.ready)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            s1_func_reg <= cmd.func;
            s1_data_reg <= cmd.data;
        end
        if (load)
        begin
            out_res_reg <= gen_emit ? gen_res : core_res;
        end
    end

    assign res.valid              = out_valid_reg;
    assign res.kind               = out_res_reg.kind;
    assign res.request_byte       = out_res_reg.request_byte;
    assign res.last               = out_res_reg.last;
    assign res.status             = out_res_reg.status;
    assign res.rom_id             = out_res_reg.rom_id;
    assign res.family_discrepancy = out_res_reg.family_discrepancy;
    assign res.last_device        = out_res_reg.last_device;

    // request burst and outcome never compete for the output register
    a_no_collision: assert property (@(posedge clk) disable iff (!rst_n)
        !(gen_emit && core_valid))
        else $error("request byte and outcome loaded together");

    // a started pass always runs the request generator next
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start_req |=> gen_busy)
        else $error("search start did not launch request burst");

    // no item leaves the input register during a request burst
    a_hold_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
        gen_busy |-> !advance)
        else $error("item processed during request burst");

    // a loaded result is shown in the next cycle
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> out_valid_reg)
        else $error("loaded result not presented");

endmodule

// ----- sv/owrs_search_core.sv -----
// ----------------------------------------------------------------------------
// owrs_search_core
// Search state, response byte decode, crc check and search outcome.
// ----------------------------------------------------------------------------
module owrs_search_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           take,
    input  logic [1:0]     func,
    input  logic [7:0]     data,
    output logic           res_valid,
    output owrs_pkg::res_t res,
    output logic           start_req,
    output logic [63:0]    stored_rom,
    output logic [6:0]     last_disc
);
    import owrs_pkg::*;

    logic [63:0]     rom_reg, rom_next;
    logic [6:0]      ld_reg, ld_next;
    logic [3:0]      fam_reg, fam_next;
    logic            done_reg, done_next;
    logic            active_reg, active_next;
    logic [4:0]      cnt_reg, cnt_next;
    logic [15:0][3:0] cand_reg, cand_next;
    logic [6:0]      nlz_reg, nlz_next;
    logic [7:0]      crc_reg, crc_next;

    logic [3:0]      nib_idx;
    logic [3:0]      prev_idx;
    logic [3:0]      nib_new;
    logic [15:0][3:0] cand_upd;
    logic [6:0]      nlz_upd;
    logic [3:0]      fam_upd;
    logic [7:0]      crc_upd;

    assign nib_idx  = 4'(cnt_reg - 5'd1);
    assign prev_idx = 4'(cnt_reg - 5'd2);

    // decode of one response byte: odd bits are rom bits, even bits discrepancy flags
    always_comb
    begin
        logic [6:0] pos;
        pos     = '0;
        nlz_upd = nlz_reg;
        fam_upd = fam_reg;
        for (int p = 0; p < 4; p++)
        begin
            nib_new[p] = data[2*p+1];
            if (data[2*p] && !data[2*p+1])
            begin
                pos     = 7'({nib_idx, 2'(p)}) + 7'd1;
                nlz_upd = pos;
                if (cnt_reg <= 5'd2)
                begin
                    fam_upd = pos[3:0];
                end
            end
        end
        cand_upd          = cand_reg;
        cand_upd[nib_idx] = nib_new;
        if (!cnt_reg[0])
        begin
            crc_upd = crc_step(crc_reg, {nib_new, cand_reg[prev_idx]});
        end
        else
        begin
            crc_upd = crc_reg;
        end
    end

    always_comb
    begin
        rom_next    = rom_reg;
        ld_next     = ld_reg;
        fam_next    = fam_reg;
        done_next   = done_reg;
        active_next = active_reg;
        cnt_next    = cnt_reg;
        cand_next   = cand_reg;
        nlz_next    = nlz_reg;
        crc_next    = crc_reg;
        res_valid   = 1'b0;
        res         = '0;
        start_req   = 1'b0;
        if (take)
        begin
            case (func_t'(func))
                FUNC_FIRST, FUNC_NEXT:
                begin
                    active_next = 1'b0;
                    if (func_t'(func) == FUNC_FIRST || done_reg)
                    begin
                        ld_next   = '0;
                        done_next = 1'b0;
                        fam_next  = '0;
                    end
                    if (func_t'(func) == FUNC_NEXT && done_reg)
                    begin
                        res_valid  = 1'b1;
                        res.kind   = KIND_OUTCOME;
                        res.last   = 1'b1;
                        res.status = STAT_NO_MORE;
                    end
                    else
                    begin
                        active_next = 1'b1;
                        cnt_next    = '0;
                        nlz_next    = '0;
                        crc_next    = '0;
                        start_req   = 1'b1;
                    end
                end
                FUNC_TARGET:
                begin
                    active_next = 1'b0;
                    rom_next    = {56'd0, data};
                    ld_next     = LD_TARGET;
                    fam_next    = '0;
                    done_next   = 1'b0;
                end
                FUNC_RESP:
                begin
                    if (active_reg)
                    begin
                        if (cnt_reg != 5'd0)
                        begin
                            cand_next = cand_upd;
                            nlz_next  = nlz_upd;
                            fam_next  = fam_upd;
                            crc_next  = crc_upd;
                        end
                        if (cnt_reg == RESP_FINAL)
                        begin
                            active_next = 1'b0;
                            cnt_next    = '0;
                            res_valid   = 1'b1;
                            res.kind    = KIND_OUTCOME;
                            res.last    = 1'b1;
                            if (crc_upd != 8'd0 || ld_reg == LD_BROKEN
                                || {cand_upd[1], cand_upd[0]} == 8'd0)
                            begin
                                ld_next    = '0;
                                done_next  = 1'b0;
                                fam_next   = '0;
                                res.status = STAT_ERROR;
                            end
                            else
                            begin
                                ld_next                = nlz_upd;
                                done_next              = (nlz_upd == 7'd0);
                                rom_next               = cand_upd;
                                res.status             = STAT_FOUND;
                                res.rom_id             = cand_upd;
                                res.family_discrepancy = fam_upd;
                                res.last_device        = (nlz_upd == 7'd0);
                            end
                        end
                        else
                        begin
                            cnt_next = cnt_reg + 5'd1;
                        end
                    end
                end
                default:
                begin
                    active_next = active_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_reg    <= '0;
            ld_reg     <= '0;
            fam_reg    <= '0;
            done_reg   <= 1'b0;
            active_reg <= 1'b0;
            cnt_reg    <= '0;
            nlz_reg    <= '0;
            crc_reg    <= '0;
        end
        else
        begin
            rom_reg    <= rom_next;
            ld_reg     <= ld_next;
            fam_reg    <= fam_next;
            done_reg   <= done_next;
            active_reg <= active_next;
            cnt_reg    <= cnt_next;
            nlz_reg    <= nlz_next;
            crc_reg    <= crc_next;
        end
    end

    // candidate is fully written during a run before it is read
    always_ff @(posedge clk)
    begin
        cand_reg <= cand_next;
    end

    assign stored_rom = rom_reg;
    assign last_disc  = ld_reg;

endmodule

// ----- sv/owrs_req_gen.sv -----
// ----------------------------------------------------------------------------
// owrs_req_gen
// Emits a pass's sixteen request bytes, one per cycle while out_free.
// ----------------------------------------------------------------------------
module owrs_req_gen (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           out_free,
    input  logic [63:0]    stored_rom,
    input  logic [6:0]     last_disc,
    output logic           busy,
    output logic           emit,
    output owrs_pkg::res_t res
);
    import owrs_pkg::*;

    logic       busy_reg, busy_next;
    logic [3:0] idx_reg, idx_next;
    logic [3:0] rom_nib;
    logic [7:0] byte_val;

    assign rom_nib = stored_rom[{idx_reg, 2'b00} +: 4];
    assign emit    = busy_reg && out_free;
    assign busy    = busy_reg;

    // path bit: stored bit below the discrepancy, one at it, zero above
    always_comb
    begin
        logic [6:0] pos;
        pos      = '0;
        byte_val = '0;
        for (int p = 0; p < 4; p++)
        begin
            pos = 7'({idx_reg, 2'(p)}) + 7'd1;
            if (last_disc != 7'd0)
            begin
                if (pos < last_disc)
                begin
                    byte_val[2*p+1] = rom_nib[p];
                end
                else if (pos == last_disc)
                begin
                    byte_val[2*p+1] = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        res              = '0;
        res.kind         = KIND_REQ;
        res.request_byte = byte_val;
        res.last         = (idx_reg == REQ_FINAL);
    end

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (start)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
        else if (emit)
        begin
            idx_next = idx_reg + 4'd1;
            if (idx_reg == REQ_FINAL)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

endmodule
